>>> rtl/core/qas_pkg.sv
`timescale 1ns / 1ps

package qas_pkg;

    localparam int NSTAGE = 23;

    typedef logic signed [15:0] q14_t;
    typedef logic [3:0][15:0]   cvec_t;

    // per-request data carried alongside the warp and lerp computation
    typedef struct packed {
        cvec_t            a;
        logic [3:0][16:0] d;
        logic [13:0]      tt;
        logic             mir;
    } carry_t;

    localparam logic        [14:0] ONE_T    = 15'd16384;
    localparam logic        [14:0] HALF_T   = 15'd8192;
    localparam logic signed [17:0] CORR_S   = 18'sd53927;
    localparam logic signed [17:0] CORR_KC  = 18'sd38372;
    localparam logic signed [16:0] THREE_Q  = 17'sd49152;
    localparam logic signed [16:0] ISQ_F    = 17'sd34899;
    localparam int                 ISQ_A    = 66941;
    localparam int                 ISQ_N    = 62853;
    localparam logic        [21:0] THRESH1  = 22'd59979;
    localparam logic        [21:0] THRESH2  = 22'd42737;

    function automatic q14_t sat16(input logic signed [31:0] v);
        q14_t r;
        if (v > 32'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -32'sd32768) begin
            r = -16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/core/quaternion_approx_slerp_core.sv
`timescale 1ns / 1ps

// Approximate quaternion slerp, corrected lerp with renormalisation.
// Input channel (s_valid/s_ready) takes two Q2.14 quaternions and a Q1.14
// blend fraction; the output channel (m_valid/m_ready) returns the blended,
// normalised quaternion in Q2.14, saturated.
// The pipeline has 23 register stages, covering the warp, lerp, norm and
// the two refinement steps of the inverse square root. It takes one request
// per cycle while it is not stalled; every request is independent.
// A single enable advances all stages together. When the receiver holds
// m_ready low with a result waiting, the whole pipeline freezes and s_ready
// drops; nothing is lost or repeated, and bubbles move through when the
// last stage is empty.
// Reset (aresetn low, synchronous) clears all valid bits; the block keeps
// no other state and takes requests as soon as aresetn is high again.
module quaternion_approx_slerp_core import qas_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  q14_t        s_from_w,
    input  q14_t        s_from_x,
    input  q14_t        s_from_y,
    input  q14_t        s_from_z,
    input  q14_t        s_to_w,
    input  q14_t        s_to_x,
    input  q14_t        s_to_y,
    input  q14_t        s_to_z,
    input  logic [14:0] s_fraction,
    output logic        m_valid,
    input  logic        m_ready,
    output q14_t        m_out_w,
    output q14_t        m_out_x,
    output q14_t        m_out_y,
    output q14_t        m_out_z
);

    logic [NSTAGE-1:0] vld_reg;
    logic              en;

    q14_t        a_in [4];
    q14_t        b_in [4];
    logic [14:0] t_cl;
    logic        mir_in;
    logic [14:0] tt_in;
    carry_t      carry_in;

    carry_t                    carry_reg [1:9];
    logic signed [31:0]        prod1_reg [4];
    logic signed [19:0]        cosv2_reg;
    logic signed [37:0]        m3_reg;
    logic signed [45:0]        ff4_reg;
    logic signed [40:0]        kp5_reg;
    logic signed [37:0]        kt6_reg;
    logic signed [22:0]        k6_reg;
    logic signed [38:0]        q7_reg;
    logic signed [22:0]        k7_reg;
    logic signed [40:0]        w8_reg;
    logic signed [44:0]        lp9_reg [4];
    cvec_t                     c_reg [10:22];
    logic signed [31:0]        sq11_reg [4];
    logic [21:0]               s_reg [12:21];
    logic signed [39:0]        isp13_reg;
    logic signed [25:0]        nk0_pipe_reg [14:21];
    logic signed [51:0]        kk14_reg;
    logic signed [51:0]        kk18_reg;
    logic signed [25:0]        nk1_pipe_reg [18:21];
    logic signed [46:0]        xp_reg [2];
    logic signed [41:0]        ip_reg [2];
    logic signed [52:0]        nkp_reg [2];
    logic signed [41:0]        o22_reg [4];

    logic signed [33:0] dot_sum;
    logic signed [22:0] factor4;
    logic signed [22:0] k6;
    logic signed [21:0] kt7;
    logic signed [16:0] coef7;
    logic signed [25:0] br8;
    logic signed [26:0] wv9;
    logic signed [27:0] tw9;
    logic signed [33:0] sq_sum;
    logic signed [25:0] nk0;
    logic signed [25:0] nk1c;
    logic signed [25:0] nk2c;
    logic signed [25:0] nk_sel;
    logic signed [51:0] kk_src [2];
    logic [21:0]        s_src [2];
    logic signed [25:0] nk_src [2];
    logic signed [26:0] isq_v [2];

    assign en      = m_ready || !vld_reg[NSTAGE-1];
    assign s_ready = en && aresetn;
    assign m_valid = vld_reg[NSTAGE-1];

    always_comb begin
        a_in[0] = s_from_w;
        a_in[1] = s_from_x;
        a_in[2] = s_from_y;
        a_in[3] = s_from_z;
        b_in[0] = s_to_w;
        b_in[1] = s_to_x;
        b_in[2] = s_to_y;
        b_in[3] = s_to_z;
        t_cl    = (s_fraction > 15'(ONE_T)) ? 15'(ONE_T) : s_fraction;
        mir_in  = t_cl > HALF_T;
        tt_in   = mir_in ? (15'(ONE_T) - t_cl) : t_cl;
        for (int i = 0; i < 4; i++) begin
            carry_in.a[i] = a_in[i];
            carry_in.d[i] = 17'({b_in[i][15], b_in[i]} - {a_in[i][15], a_in[i]});
        end
        carry_in.tt  = tt_in[13:0];
        carry_in.mir = mir_in;
    end

    // warp and lerp path
    assign dot_sum = 34'(prod1_reg[0]) + 34'(prod1_reg[1])
                   + 34'(prod1_reg[2]) + 34'(prod1_reg[3]);
    assign factor4 = 23'sd16384 - 23'($signed(m3_reg[37:16]));
    assign k6      = $signed(kp5_reg[38:16]);
    assign kt7     = $signed(kt6_reg[35:14]);
    assign coef7   = $signed({2'b00, carry_reg[6].tt, 1'b0}) - THREE_Q;
    assign br8     = 26'($signed(q7_reg[38:14])) + 26'sd16384 + 26'(k7_reg);
    assign wv9     = $signed(w8_reg[40:14]);
    assign tw9     = carry_reg[8].mir ? (28'sd16384 - 28'(wv9)) : 28'(wv9);

    // norm and inverse square root path
    assign sq_sum = 34'(sq11_reg[0]) + 34'(sq11_reg[1])
                  + 34'(sq11_reg[2]) + 34'(sq11_reg[3]);
    assign nk0    = 26'sd66941 - 26'($signed(isp13_reg[39:16]));
    assign nk1c   = $signed(nkp_reg[0][41:16]);
    assign nk2c   = $signed(nkp_reg[1][41:16]);

    always_comb begin
        kk_src[0] = kk14_reg;
        kk_src[1] = kk18_reg;
        s_src[0]  = s_reg[14];
        s_src[1]  = s_reg[18];
        nk_src[0] = nk0_pipe_reg[16];
        nk_src[1] = nk1_pipe_reg[20];
        for (int r = 0; r < 2; r++) begin
            isq_v[r] = 27'(ISQ_A) - 27'($signed(ip_reg[r][41:16]));
        end
        if (s_reg[21] <= THRESH2) begin
            nk_sel = nk2c;
        end else if (s_reg[21] <= THRESH1) begin
            nk_sel = nk1_pipe_reg[21];
        end else begin
            nk_sel = nk0_pipe_reg[21];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NSTAGE-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            carry_reg[1] <= carry_in;
            for (int st = 2; st <= 9; st++) begin
                carry_reg[st] <= carry_reg[st-1];
            end
            for (int i = 0; i < 4; i++) begin
                prod1_reg[i] <= a_in[i] * b_in[i];
            end
            cosv2_reg <= dot_sum[33:14];
            m3_reg    <= CORR_S * cosv2_reg;
            ff4_reg   <= factor4 * factor4;
            kp5_reg   <= CORR_KC * $signed(ff4_reg[36:14]);
            kt6_reg   <= k6 * $signed({1'b0, carry_reg[5].tt});
            k6_reg    <= k6;
            q7_reg    <= kt7 * coef7;
            k7_reg    <= k6_reg;
            w8_reg    <= $signed({1'b0, carry_reg[7].tt}) * br8;
            for (int i = 0; i < 4; i++) begin
                lp9_reg[i]   <= tw9 * $signed(carry_reg[8].d[i]);
                c_reg[10][i] <= sat16(32'($signed(carry_reg[9].a[i]))
                                      + 32'($signed(lp9_reg[i][44:14])));
                sq11_reg[i]  <= $signed(c_reg[10][i]) * $signed(c_reg[10][i]);
            end
            for (int st = 11; st <= 22; st++) begin
                c_reg[st] <= c_reg[st-1];
            end
            s_reg[12] <= sq_sum[33:12];
            for (int st = 13; st <= 21; st++) begin
                s_reg[st] <= s_reg[st-1];
            end
            isp13_reg <= (23'($signed({1'b0, s_reg[12]})) - 23'(ISQ_N)) * ISQ_F;
            nk0_pipe_reg[14] <= nk0;
            kk14_reg         <= nk0 * nk0;
            for (int st = 15; st <= 21; st++) begin
                nk0_pipe_reg[st] <= nk0_pipe_reg[st-1];
            end
            // two refinement steps of the inverse square root
            for (int r = 0; r < 2; r++) begin
                xp_reg[r]  <= $signed(kk_src[r][39:16]) * $signed({1'b0, s_src[r]});
                ip_reg[r]  <= (25'($signed(xp_reg[r][39:16])) - 25'(ISQ_N)) * ISQ_F;
                nkp_reg[r] <= nk_src[r] * isq_v[r];
            end
            nk1_pipe_reg[18] <= nk1c;
            kk18_reg         <= nk1c * nk1c;
            for (int st = 19; st <= 21; st++) begin
                nk1_pipe_reg[st] <= nk1_pipe_reg[st-1];
            end
            for (int i = 0; i < 4; i++) begin
                o22_reg[i] <= $signed(c_reg[21][i]) * nk_sel;
            end
            m_out_w <= sat16(32'($signed(o22_reg[0][41:16])));
            m_out_x <= sat16(32'($signed(o22_reg[1][41:16])));
            m_out_y <= sat16(32'($signed(o22_reg[2][41:16])));
            m_out_z <= sat16(32'($signed(o22_reg[3][41:16])));
        end
    end

`ifndef SYNTH
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("valid bits not cleared by reset");

    a_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");

    a_norm_nonneg: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[11] |-> !s_reg[12][21])
        else $error("squared norm negative");

    a_zero_w: assert property (@(posedge aclk) disable iff (!aresetn)
        en && vld_reg[21] && c_reg[22][0] == 16'd0 |=> m_out_w == 16'sd0)
        else $error("zero component not zero at output");
`endif

endmodule

>>> tb/quaternion_approx_slerp_core_tb.sv
`timescale 1ns / 1ps

module quaternion_approx_slerp_core_tb;
    import qas_pkg::*;

    typedef struct {
        q14_t        fw, fx, fy, fz, tw, tx, ty, tz;
        logic [14:0] frac;
    } slerp_req_t;

    typedef struct {
        q14_t w, x, y, z;
    } quat_t;

    localparam longint ONE_Q = 16384;
    localparam longint HALF_Q = 8192;
    localparam longint THREE_Q14 = 49152;
    localparam longint S_CORR = 53927;
    localparam longint KC_CORR = 38372;
    localparam longint A_ISQ = 66941;
    localparam longint N_ISQ = 62853;
    localparam longint F_ISQ = 34899;
    localparam longint THR_ONE = 59979;
    localparam longint THR_TWO = 42737;
    localparam int     N_RANDOM = 1950;
    localparam longint CYCLE_LIMIT = 400000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    q14_t s_from_w = '0, s_from_x = '0, s_from_y = '0, s_from_z = '0;
    q14_t s_to_w = '0, s_to_x = '0, s_to_y = '0, s_to_z = '0;
    logic [14:0] s_fraction = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    q14_t m_out_w, m_out_x, m_out_y, m_out_z;

    int  n_errors = 0;
    int  n_sent = 0;
    int  n_checked = 0;
    int  n_saturated = 0;
    bit  stim_done = 1'b0;
    bit  hold_off = 1'b0;
    longint n_cycles = 0;

    always #4 aclk = ~aclk;

    quaternion_approx_slerp_core dut (.*);

    // shifts round towards minus infinity, as >>> does on signed longint
    function automatic longint fl(longint v, int sh);
        return v >>> sh;
    endfunction

    function automatic longint clamp16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint warp_frac(longint t, longint k);
        longint kt, br;
        kt = fl(k * t, 14);
        br = fl(kt * (2 * t - THREE_Q14), 14) + ONE_Q + k;
        return fl(t * br, 14);
    endfunction

    function automatic longint inv_sqrt_lin(longint x);
        return A_ISQ - fl((x - N_ISQ) * F_ISQ, 16);
    endfunction

    function automatic longint newton_step(longint k, longint s);
        longint kk;
        kk = fl(k * k, 16);
        return fl(k * inv_sqrt_lin(fl(kk * s, 16)), 16);
    endfunction

    function automatic quat_t predict_blend(slerp_req_t r);
        longint a[4], b[4], c[4];
        longint dot, cosv, fac, ff, k, t, tw, sq, s, nk;
        quat_t q;
        a = '{r.fw, r.fx, r.fy, r.fz};
        b = '{r.tw, r.tx, r.ty, r.tz};
        dot = 0;
        sq = 0;
        for (int i = 0; i < 4; i++) dot += a[i] * b[i];
        t = r.frac;
        if (t > ONE_Q) t = ONE_Q;
        cosv = fl(dot, 14);
        fac = ONE_Q - fl(S_CORR * cosv, 16);
        ff = fl(fac * fac, 14);
        k = fl(KC_CORR * ff, 16);
        tw = (t <= HALF_Q) ? warp_frac(t, k) : ONE_Q - warp_frac(ONE_Q - t, k);
        for (int i = 0; i < 4; i++) begin
            c[i] = clamp16(a[i] + fl(tw * (b[i] - a[i]), 14));
            sq += c[i] * c[i];
        end
        s = fl(sq, 12);
        nk = inv_sqrt_lin(s);
        if (s <= THR_ONE) begin
            nk = newton_step(nk, s);
            if (s <= THR_TWO) nk = newton_step(nk, s);
        end
        q.w = q14_t'(clamp16(fl(c[0] * nk, 16)));
        q.x = q14_t'(clamp16(fl(c[1] * nk, 16)));
        q.y = q14_t'(clamp16(fl(c[2] * nk, 16)));
        q.z = q14_t'(clamp16(fl(c[3] * nk, 16)));
        return q;
    endfunction

    task automatic report_mismatch(string what, int idx, longint got, longint want);
        $display("MISMATCH result %0d %s: got %0d expected %0d", idx, what, got, want);
        n_errors++;
    endtask

    class blend_scoreboard;
        quat_t pending[$];

        function void note_request(slerp_req_t r);
            pending.push_back(predict_blend(r));
        endfunction

        task check_result(quat_t got);
            quat_t e;
            if (pending.size() == 0) begin
                $display("MISMATCH unexpected result %0d", n_checked);
                n_errors++;
            end else begin
                e = pending.pop_front();
                if (got.w !== e.w) report_mismatch("out_w", n_checked, got.w, e.w);
                if (got.x !== e.x) report_mismatch("out_x", n_checked, got.x, e.x);
                if (got.y !== e.y) report_mismatch("out_y", n_checked, got.y, e.y);
                if (got.z !== e.z) report_mismatch("out_z", n_checked, got.z, e.z);
                if (e.w == 32767 || e.w == -32768) n_saturated++;
            end
            n_checked++;
        endtask
    endclass

    blend_scoreboard sb = new();

    function automatic q14_t rand_comp();
        case ($urandom_range(0, 9))
            0: return q14_t'($urandom);
            1: return $urandom_range(0, 1) ? 16'sh7fff : -16'sh8000;
            2: return q14_t'($urandom_range(0, 2) * 16384 - 16384);
            default: return q14_t'(int'($urandom_range(0, 16384)) - 8192);
        endcase
    endfunction

    function automatic slerp_req_t rand_req();
        slerp_req_t r;
        r.fw = rand_comp(); r.fx = rand_comp(); r.fy = rand_comp(); r.fz = rand_comp();
        r.tw = rand_comp(); r.tx = rand_comp(); r.ty = rand_comp(); r.tz = rand_comp();
        case ($urandom_range(0, 7))
            0: r.frac = 15'($urandom);
            1: r.frac = $urandom_range(0, 1) ? 15'd0 : 15'd16384;
            2: r.frac = 15'($urandom_range(8190, 8194));
            default: r.frac = 15'($urandom_range(0, 16384));
        endcase
        return r;
    endfunction

    task automatic send_request(slerp_req_t r);
        s_valid <= 1'b1;
        s_from_w <= r.fw; s_from_x <= r.fx; s_from_y <= r.fy; s_from_z <= r.fz;
        s_to_w <= r.tw; s_to_x <= r.tx; s_to_y <= r.ty; s_to_z <= r.tz;
        s_fraction <= r.frac;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(r);
        n_sent++;
        @(negedge aclk);
    endtask

    task automatic idle_gap(int n);
        s_valid <= 1'b0;
        repeat (n) @(negedge aclk);
    endtask

    function automatic slerp_req_t make_req(q14_t w0, q14_t x0, q14_t y0, q14_t z0,
                                            q14_t w1, q14_t x1, q14_t y1, q14_t z1,
                                            logic [14:0] f);
        slerp_req_t r;
        r = '{w0, x0, y0, z0, w1, x1, y1, z1, f};
        return r;
    endfunction

    // stimulus
    initial begin
        slerp_req_t r;
        int burst;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        // identity to identity, extremes of the fraction, over-range fraction
        send_request(make_req(16384, 0, 0, 0, 16384, 0, 0, 0, 0));
        send_request(make_req(16384, 0, 0, 0, 0, 16384, 0, 0, 0));
        send_request(make_req(16384, 0, 0, 0, 0, 16384, 0, 0, 16384));
        send_request(make_req(16384, 0, 0, 0, 0, 16384, 0, 0, 8192));
        send_request(make_req(16384, 0, 0, 0, 0, 16384, 0, 0, 8193));
        send_request(make_req(16384, 0, 0, 0, 0, 0, 16384, 0, 15'h7fff));
        send_request(make_req(16384, 0, 0, 0, 0, 0, 0, 16384, 20000));
        // opposite quaternions, blend through zero
        send_request(make_req(16384, 0, 0, 0, -16384, 0, 0, 0, 8192));
        send_request(make_req(0, 0, 0, 0, 0, 0, 0, 0, 4000));
        // saturating inputs
        send_request(make_req(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                              -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, 3000));
        send_request(make_req(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000,
                              -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, 16384));
        send_request(make_req(16'sh7fff, -16'sh8000, 16'sh7fff, -16'sh8000,
                              -16'sh8000, 16'sh7fff, -16'sh8000, 16'sh7fff, 12000));
        // small norms, one or both refinements
        send_request(make_req(6000, 2000, 0, 0, 5000, -2000, 1000, 0, 7000));
        send_request(make_req(100, 0, -50, 0, 0, 80, 0, 60, 9000));
        send_request(make_req(15000, 3000, 0, 0, 14000, 0, 3000, 0, 11000));
        send_request(make_req(-1, -1, -1, -1, 1, 1, 1, 1, 1));
        idle_gap(2);
        while (n_sent < N_RANDOM + 16) begin
            burst = $urandom_range(1, 40);
            repeat (burst) send_request(rand_req());
            if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 6));
        end
        s_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // receiver: stall pattern plus one long hold-off mid-run
    initial begin
        int phase;
        m_ready <= 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            phase = (n_checked / 200) % 4;
            if (!hold_off && n_sent > 600 && n_sent < 700 && n_checked > 50) begin
                hold_off = 1'b1;
                m_ready <= 1'b0;
                repeat (120) @(negedge aclk);
            end
            case (phase)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                2: m_ready <= ($urandom_range(0, 1) != 0);
                default: m_ready <= (n_cycles % 7) < 4;
            endcase
        end
    end

    always @(posedge aclk) begin
        n_cycles <= n_cycles + 1;
        if (aresetn && m_valid && m_ready)
            sb.check_result('{m_out_w, m_out_x, m_out_y, m_out_z});
    end

    initial begin
        wait (stim_done);
        while (sb.pending.size() != 0 && n_cycles < CYCLE_LIMIT) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", n_cycles);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            $display("Blended %0d quaternion requests (%0d saturated w) under random stalls",
                     n_checked, n_saturated);
            if (n_errors == 0 && sb.pending.size() == 0)
                $display("ALL CHECKS PASSED");
            else begin
                $display("%0d mismatches, %0d results missing", n_errors, sb.pending.size());
                $display("CHECKS FAILED");
            end
            $finish;
        end
    end

    initial begin
        wait (n_cycles >= CYCLE_LIMIT);
        $display("timeout: run exceeded %0d cycles", CYCLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
